// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- sv/qps_pkg.sv -----
// ----------------------------------------------------------------------------
// qps_pkg
// Shared types, codes and helpers of the quadrature position servo.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qps_pkg;

	localparam int POS_W   = 32;
	localparam int GAIN_W  = 8;
	localparam int SPEED_W = 12;
	localparam int CFG_W   = 12;
	localparam int IN_W    = 40;
	localparam int OUT_W   = 80;

	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_CW   = 2'd1;
	localparam logic [1:0] DIR_ACW  = 2'd2;

	localparam int CW_BIT  = 30;
	localparam int ACW_BIT = 31;

	localparam logic REG_GAIN  = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

	localparam logic [GAIN_W-1:0]  GAIN_RESET  = 8'd48;
	localparam logic [SPEED_W-1:0] LIMIT_RESET = 12'd768;

	typedef struct packed {
		logic [1:0]         dir;
		logic               err_big;
		logic [SPEED_W-1:0] err_lo;
		logic [POS_W-1:0]   position;
	} qps_err_t;

	// successor in the count-up gray sequence 0,1,3,2
	function automatic logic [1:0] next_up(input logic [1:0] c);
		logic [1:0] r;
		case (c)
			2'd0:    r = 2'd1;
			2'd1:    r = 2'd3;
			2'd3:    r = 2'd2;
			2'd2:    r = 2'd0;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- sv/qps_decoder.sv -----
// ----------------------------------------------------------------------------
// qps_decoder
// Quadrature step decode, position count and the input stage register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qps_decoder import qps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             chan_a,
	input  logic             chan_b,
	input  logic [POS_W-1:0] target_position,
	output logic [POS_W-1:0] position,
	output logic [POS_W-1:0] target_s1
);

	logic [1:0]       prev_code_q;
	logic [POS_W-1:0] count_q;
	logic [1:0]       code;
	logic             step_up;
	logic             step_dn;
	logic [POS_W-1:0] count_nxt;

	assign code    = {chan_a, chan_b};
	assign step_up = (next_up(prev_code_q) == code);
	assign step_dn = (next_up(code) == prev_code_q);

	always_comb begin
		count_nxt = count_q;
		if (step_up)
			count_nxt = count_q + POS_W'(1);
		else if (step_dn)
			count_nxt = count_q - POS_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_code_q <= 2'd0;
			count_q     <= '0;
		end else if (load) begin
			prev_code_q <= code;
			count_q     <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			target_s1 <= target_position;
	end

	assign position = count_q;

endmodule

// ----- sv/qps_error.sv -----
// ----------------------------------------------------------------------------
// qps_error
// Position error, direction and error magnitude split for the gain stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qps_error import qps_pkg::*; (
	input  logic             clk,
	input  logic             load,
	input  logic [POS_W-1:0] position,
	input  logic [POS_W-1:0] target,
	output qps_err_t         err_s2
);

	logic [POS_W:0]   d_pt;
	logic [POS_W:0]   d_tp;
	logic [POS_W-1:0] mag;
	qps_err_t         err_d;

	assign d_pt = {position[POS_W-1], position} - {target[POS_W-1], target};
	assign d_tp = {target[POS_W-1], target} - {position[POS_W-1], position};

	always_comb begin
		err_d.position = position;
		if (d_pt == '0) begin
			err_d.dir = DIR_STOP;
			mag       = '0;
		end else if (!d_pt[POS_W]) begin
			err_d.dir = DIR_CW;
			mag       = d_pt[POS_W-1:0];
		end else begin
			err_d.dir = DIR_ACW;
			mag       = d_tp[POS_W-1:0];
		end
		err_d.err_lo  = mag[SPEED_W-1:0];
		err_d.err_big = |mag[POS_W-1:SPEED_W];
	end

	always_ff @(posedge clk) begin
		if (load)
			err_s2 <= err_d;
	end

endmodule

// ----- sv/qps_drive.sv -----
// ----------------------------------------------------------------------------
// qps_drive
// Gain multiply, speed saturation and drive word; result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qps_drive import qps_pkg::*; (
	input  logic               clk,
	input  logic               load,
	input  qps_err_t           err_s2,
	input  logic [GAIN_W-1:0]  gain,
	input  logic [SPEED_W-1:0] speed_limit,
	output logic [1:0]         direction_q,
	output logic [SPEED_W-1:0] speed_q,
	output logic [POS_W-1:0]   drive_word_q,
	output logic [POS_W-1:0]   position_q
);

	logic [SPEED_W+GAIN_W-1:0] prod;
	logic [SPEED_W-1:0]        spd;
	logic [POS_W-1:0]          word;

	assign prod = err_s2.err_lo * gain;

	always_comb begin
		word = '0;
		if (err_s2.dir == DIR_STOP)
			spd = '0;
		else if (err_s2.err_big && (gain != '0))
			spd = speed_limit;
		else if (prod > (SPEED_W+GAIN_W)'(speed_limit))
			spd = speed_limit;
		else
			spd = prod[SPEED_W-1:0];
		word[SPEED_W-1:0] = spd;
		word[CW_BIT]      = (err_s2.dir == DIR_CW);
		word[ACW_BIT]     = (err_s2.dir == DIR_ACW);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			direction_q  <= err_s2.dir;
			speed_q      <= spd;
			drive_word_q <= word;
			position_q   <= err_s2.position;
		end
	end

endmodule

// ----- sv/quadrature_position_servo_unit.sv -----
// ----------------------------------------------------------------------------
// quadrature_position_servo_unit
// Quadrature encoder counter with proportional position drive command.
// ----------------------------------------------------------------------------
// Input stream s_*: one transfer per encoder sample, carrying the A/B levels
// and the target position. Output stream m_*: one result per sample with the
// direction, saturated speed, motor drive word and updated position count.
// Config port: cfg_wen/cfg_addr/cfg_wdata, index 0 gain, index 1 speed limit;
// write only while the block is idle.
// Pipeline: three register stages (count update, error, gain/saturation); a
// sample's result passes through them in that order before it is presented.
// Throughput: one sample per cycle, set by the count update loop, barring output stalls.
// Each stage loads whenever it is empty or its successor loads, so input is
// taken while a result waits, until all stages fill during an output stall.
// Reset clears the position count, the previous A/B code (to 00), all valid
// flags and sets gain 48 and speed limit 768.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module quadrature_position_servo_unit import qps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // chan_a, chan_b, target_position[31:0], pad
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // direction[1:0], speed[11:0], drive_word[31:0],
	                                    // position[31:0], pad
	input  logic             cfg_wen,
	input  logic             cfg_addr,
	input  logic [CFG_W-1:0] cfg_wdata
);

	logic [GAIN_W-1:0]  gain_q;
	logic [SPEED_W-1:0] speed_limit_q;
	logic               v1_q;
	logic               v2_q;
	logic               vo_q;
	logic               en1;
	logic               en2;
	logic               en3;
	logic               in_xfer;
	logic [POS_W-1:0]   position;
	logic [POS_W-1:0]   target_s1;
	qps_err_t           err_s2;
	logic [1:0]         direction_q;
	logic [SPEED_W-1:0] speed_q;
	logic [POS_W-1:0]   drive_word_q;
	logic [POS_W-1:0]   position_q;

	assign en3      = !vo_q || m_tready;
	assign en2      = !v2_q || en3;
	assign en1      = !v1_q || en2;
	assign s_tready = en1;
	assign in_xfer  = s_tvalid && en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q        <= GAIN_RESET;
			speed_limit_q <= LIMIT_RESET;
		end else if (cfg_wen) begin
			case (cfg_addr)
				REG_GAIN:  gain_q        <= cfg_wdata[GAIN_W-1:0];
				REG_LIMIT: speed_limit_q <= cfg_wdata[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (en1)
				v1_q <= s_tvalid;
			if (en2)
				v2_q <= v1_q;
			if (en3)
				vo_q <= v2_q;
		end
	end

	qps_decoder u_decoder (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (in_xfer),
		.chan_a          (s_tdata[0]),
		.chan_b          (s_tdata[1]),
		.target_position (s_tdata[POS_W+1:2]),
		.position        (position),
		.target_s1       (target_s1)
	);

	qps_error u_error (
		.clk      (clk),
		.load     (en2),
		.position (position),
		.target   (target_s1),
		.err_s2   (err_s2)
	);

	qps_drive u_drive (
		.clk          (clk),
		.load         (en3),
		.err_s2       (err_s2),
		.gain         (gain_q),
		.speed_limit  (speed_limit_q),
		.direction_q  (direction_q),
		.speed_q      (speed_q),
		.drive_word_q (drive_word_q),
		.position_q   (position_q)
	);

	assign m_tvalid = vo_q;
	assign m_tdata  = {2'b00, position_q, drive_word_q, speed_q, direction_q};

	`ASSERT_IMPL(a_stop_quiet, clk, arst_n,
		m_tvalid && (direction_q == DIR_STOP),
		(speed_q == '0) && (drive_word_q == '0),
		"stopped result with nonzero speed or drive word")

	`ASSERT_IMPL(a_speed_cap, clk, arst_n, m_tvalid, speed_q <= speed_limit_q,
		"speed above limit")

	`ASSERT_IMPL(a_word_dir, clk, arst_n, m_tvalid,
		(drive_word_q[CW_BIT] == (direction_q == DIR_CW)) &&
		(drive_word_q[ACW_BIT] == (direction_q == DIR_ACW)),
		"drive word direction bits disagree with direction")

	`ASSERT_NEXT(a_count_step, clk, arst_n, 1'b1,
		(position == $past(position)) || (position == $past(position) + POS_W'(1)) ||
		(position == $past(position) - POS_W'(1)),
		"position count moved by more than one")

endmodule

// ----- dv/tb_quadrature_position_servo_unit.sv -----
// ----------------------------------------------------------------------------
// tb_quadrature_position_servo_unit
// Self-checking bench for the quadrature position servo.
// ----------------------------------------------------------------------------
// Drives encoder samples with target positions over the input stream. A
// scoreboard model tracks the A/B code, the position count and the gain and
// speed limit registers, and predicts direction, speed, drive word and
// position for every accepted sample. Each output transfer is checked field by
// field against the oldest prediction. Directed tests cover Gray counting in
// both directions, invalid steps, equal target, saturation and the register
// extremes. Random phases then run well-formed step walks mixed with holds and
// invalid steps, under different handshake pressure and register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quadrature_position_servo_unit;
	import qps_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RAND_ITEMS  = 240;

	localparam logic [1:0] GRAY_SUCC [4] = '{2'd1, 2'd3, 2'd0, 2'd2};
	localparam logic [1:0] GRAY_PRED [4] = '{2'd2, 2'd0, 2'd3, 2'd1};

	typedef enum logic [1:0] {STEP_UP, STEP_DOWN, STEP_HOLD, STEP_SKIP} step_kind_t;

	typedef struct packed {
		logic [1:0]               direction;
		logic [SPEED_W-1:0]       speed;
		logic [31:0]              drive_word;
		logic signed [POS_W-1:0]  position;
	} servo_cmd_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic             cfg_wen;
	logic             cfg_addr;
	logic [CFG_W-1:0] cfg_wdata;

	// scoreboard copy of the block state
	logic [1:0]              trk_prev_code;
	logic signed [POS_W-1:0] trk_count;
	logic [GAIN_W-1:0]       trk_gain;
	logic [SPEED_W-1:0]      trk_limit;

	servo_cmd_t pending_cmds [$];

	int send_idle_pct;
	int recv_stall_pct;
	int fail_count;
	int checked_count;
	int cycle_count;
	int step_tally [4];

	quadrature_position_servo_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wen  (cfg_wen),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic signed [POS_W-1:0] step_count(input logic [1:0] prev,
			input logic [1:0] code, input logic signed [POS_W-1:0] cnt);
		if (code == GRAY_SUCC[prev])
			return cnt + 1;
		else if (prev == GRAY_SUCC[code])
			return cnt - 1;
		return cnt;
	endfunction

	function automatic servo_cmd_t predict_drive(input logic [1:0] code,
			input logic signed [POS_W-1:0] tgt);
		servo_cmd_t r;
		longint mag;
		longint prod;
		r = '0;
		mag = 0;
		trk_count = step_count(trk_prev_code, code, trk_count);
		trk_prev_code = code;
		r.position = trk_count;
		if (tgt < trk_count) begin
			r.direction = DIR_CW;
			mag = longint'(trk_count) - longint'(tgt);
		end else if (tgt > trk_count) begin
			r.direction = DIR_ACW;
			mag = longint'(tgt) - longint'(trk_count);
		end
		if (r.direction != DIR_STOP) begin
			prod = mag * longint'(trk_gain);
			r.speed = (prod > longint'(trk_limit)) ? trk_limit : prod[SPEED_W-1:0];
			r.drive_word = {20'd0, r.speed};
			if (r.direction == DIR_CW)
				r.drive_word[CW_BIT] = 1'b1;
			else
				r.drive_word[ACW_BIT] = 1'b1;
		end
		return r;
	endfunction

	// input side: predict on every accepted sample
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			pending_cmds.push_back(predict_drive({s_tdata[0], s_tdata[1]}, s_tdata[33:2]));
	end

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// output side: compare each transfer with the oldest prediction
	always @(posedge clk) begin
		servo_cmd_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_cmds.size() == 0) begin
				$display("%0t: unexpected result, expected none, got 0x%0h", $time, m_tdata);
				fail_count++;
			end else begin
				want = pending_cmds.pop_front();
				check_field("direction", 32'(want.direction), 32'(m_tdata[1:0]));
				check_field("speed", 32'(want.speed), 32'(m_tdata[13:2]));
				check_field("drive_word", want.drive_word, m_tdata[45:14]);
				check_field("position", want.position, m_tdata[77:46]);
				checked_count++;
			end
		end
	end

	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Verification failed");
			$finish;
		end
	end

	// called at a falling edge, returns at a falling edge after the transfer
	task automatic send_sample(input logic a, input logic b, input logic signed [31:0] tgt);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, tgt, b, a};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic addr, input logic [CFG_W-1:0] data);
		cfg_wen   <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_wen <= 1'b0;
		if (addr == REG_GAIN)
			trk_gain = data[GAIN_W-1:0];
		else
			trk_limit = data;
	endtask

	// Gray steps both ways, invalid double-bit change, count below zero,
	// equal target and saturation at the reset register values
	task automatic test_gray_counting();
		send_sample(1'b0, 1'b0, 0);
		send_sample(1'b1, 1'b0, -1);
		send_sample(1'b1, 1'b1, 0);
		send_sample(1'b0, 1'b0, -10);
		send_sample(1'b0, 1'b1, 32'sh7FFF_FFFF);
		send_sample(1'b1, 1'b1, 32'sh8000_0000);
		send_sample(1'b1, 1'b0, 1);
		send_sample(1'b0, 1'b0, 18);
		send_sample(1'b0, 1'b0, -15);
		send_sample(1'b0, 1'b1, 3);
		send_sample(1'b1, 1'b0, 0);
		wait_drain();
	endtask

	// gain and speed limit at their extremes, just below and at saturation
	task automatic test_register_extremes();
		write_reg(REG_GAIN, 12'd255);
		write_reg(REG_LIMIT, 12'd4095);
		send_sample(1'b1, 1'b0, 19);
		send_sample(1'b1, 1'b0, 20);
		send_sample(1'b1, 1'b0, 32'sh8000_0000);
		wait_drain();
		write_reg(REG_GAIN, 12'd0);
		send_sample(1'b1, 1'b0, 100);
		send_sample(1'b1, 1'b0, 3);
		wait_drain();
		write_reg(REG_GAIN, 12'd1);
		write_reg(REG_LIMIT, 12'd0);
		send_sample(1'b1, 1'b0, -5);
		wait_drain();
		write_reg(REG_GAIN, 12'd7);
		write_reg(REG_LIMIT, 12'd1234);
		send_sample(1'b1, 1'b1, 32'sh7FFF_FFFF);
		send_sample(1'b1, 1'b1, -48);
		wait_drain();
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_pct,
			input logic [GAIN_W-1:0] gain, input logic [SPEED_W-1:0] limit,
			input bit mid_drain);
		step_kind_t kind;
		logic [1:0] code;
		logic signed [31:0] nc;
		logic signed [31:0] tgt;
		int sel;
		write_reg(REG_GAIN, {4'd0, gain});
		write_reg(REG_LIMIT, limit);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (mid_drain && i == RAND_ITEMS / 2)
				wait_drain();
			sel = $urandom_range(0, 99);
			kind = (sel < 42) ? STEP_UP : (sel < 84) ? STEP_DOWN :
				(sel < 92) ? STEP_HOLD : STEP_SKIP;
			case (kind)
				STEP_UP:   code = GRAY_SUCC[trk_prev_code];
				STEP_DOWN: code = GRAY_PRED[trk_prev_code];
				STEP_HOLD: code = trk_prev_code;
				default:   code = ~trk_prev_code;
			endcase
			step_tally[kind]++;
			nc = step_count(trk_prev_code, code, trk_count);
			sel = $urandom_range(0, 99);
			if (sel < 45)
				tgt = nc + $signed($urandom_range(0, 80)) - 40;
			else if (sel < 55)
				tgt = nc;
			else if (sel < 75)
				tgt = nc + $signed($urandom_range(0, 131071)) - 65536;
			else
				tgt = $urandom;
			send_sample(code[1], code[0], tgt);
		end
		wait_drain();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		m_tready       = 1'b0;
		cfg_wen        = 1'b0;
		cfg_addr       = REG_GAIN;
		cfg_wdata      = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		fail_count     = 0;
		checked_count  = 0;
		cycle_count    = 0;
		step_tally     = '{0, 0, 0, 0};
		trk_prev_code  = 2'd0;
		trk_count      = '0;
		trk_gain       = GAIN_RESET;
		trk_limit      = LIMIT_RESET;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_gray_counting();
		test_register_extremes();
		test_random_phase(0, 0, GAIN_RESET, LIMIT_RESET, 1'b0);
		test_random_phase(55, 0, 8'd255, 12'd4095, 1'b1);
		test_random_phase(0, 55, 8'd0, 12'd1, 1'b0);
		test_random_phase(38, 38, GAIN_W'($urandom_range(1, 254)),
			SPEED_W'($urandom_range(1, 4094)), 1'b0);

		repeat (10) @(posedge clk);
		if (pending_cmds.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_cmds.size());
			fail_count += pending_cmds.size();
		end
		$display("Checked %0d drive commands over four handshake phases", checked_count);
		$display("Steps up %0d, down %0d, hold %0d, invalid %0d; gain and limit swept to extremes",
			step_tally[STEP_UP], step_tally[STEP_DOWN], step_tally[STEP_HOLD],
			step_tally[STEP_SKIP]);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
